// File: rtl/sync_word_correlator_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef SYNC_WORD_CORRELATOR_UNIT_ASSERT_SVH
`define SYNC_WORD_CORRELATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Consequent must hold in the cycle after the antecedent.
`define SWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

// Checked with reset included: the consequent follows a reset cycle.
`define SWC_ASSERT_AFTER_RST(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: rtl/swc_pkg.sv
package swc_pkg;

  localparam int CODE_W = 64;   // sync word register width
  localparam int LEN_W  = 7;    // code_length / threshold / mismatch count width
  localparam int IDX_W  = 2;    // configuration register index width

  typedef enum logic [IDX_W-1:0] {
    REG_CODE_WORD   = 2'd0,
    REG_CODE_LENGTH = 2'd1,
    REG_THRESHOLD   = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic data_out;
    logic match_flag;
  } result_t;

  localparam logic [LEN_W-1:0] CODE_LENGTH_RST = 7'd64;

  // Population count of a code-wide word as a balanced adder tree:
  // add neighbor pairs level by level, six levels for 64 bits.
  function automatic logic [LEN_W-1:0] count_ones(input logic [CODE_W-1:0] v);
    logic [LEN_W-1:0] part [CODE_W];
    for (int i = 0; i < CODE_W; i++) begin
      part[i] = LEN_W'(v[i]);
    end
    for (int step = 1; step < CODE_W; step = step * 2) begin
      for (int i = 0; i < CODE_W; i = i + 2 * step) begin
        part[i] = part[i] + part[i + step];
      end
    end
    return part[0];
  endfunction

endpackage

// File: rtl/swc_match.sv
module swc_match import swc_pkg::*; #(
  parameter int HISTORY_BITS = 64
) (
  input  logic [HISTORY_BITS-1:0] bit_history,
  input  logic [CODE_W-1:0]       code_word,
  input  logic [LEN_W-1:0]        code_length,
  input  logic [LEN_W-1:0]        threshold,
  output logic [HISTORY_BITS-1:0] flag_inject
);

  logic [CODE_W-1:0] mismatch;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  inject_pos;
  logic              hit;

  // Compare oldest history bits against the leading sync word bits.
  always_comb begin
    mismatch = '0;
    for (int k = 0; k < HISTORY_BITS; k++) begin
      if (LEN_W'(k) < code_length) begin
        mismatch[k] = bit_history[HISTORY_BITS-1-k] ^ code_word[CODE_W-1-k];
      end
    end
  end

  assign len_eff    = (code_length > LEN_W'(HISTORY_BITS)) ? LEN_W'(HISTORY_BITS) : code_length;
  assign hit        = (code_length != '0) && (count_ones(mismatch) <= threshold);
  assign inject_pos = LEN_W'(HISTORY_BITS) - len_eff;

  always_comb begin
    for (int i = 0; i < HISTORY_BITS; i++) begin
      flag_inject[i] = hit && (inject_pos == LEN_W'(i));
    end
  end

endmodule

// File: rtl/swc_out_buf.sv
module swc_out_buf import swc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t     entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

// File: rtl/sync_word_correlator_unit.sv
// Each input transfer pushes a result into the output buffer; m_tvalid is high in the cycle after it.
// Throughput: one item per cycle while the output buffer is not full; the
//   correlate-and-shift path and two-entry buffer take an item while one result waits.
// Reset (rst, synchronous): history and flag delay line clear to zero,
//   code_word 0, code_length 64, threshold 0, output buffer empty.
module sync_word_correlator_unit import swc_pkg::*; #(
  parameter int HISTORY_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  // Input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,    // [0] data_bit, [7:1] zero
  // Result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,    // [0] data_out, [7:1] zero
  output logic                m_tuser,    // [0] match_flag
  // Configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CODE_W-1:0]   cfg_data
);

  // Configuration registers
  logic [CODE_W-1:0]       code_word;
  logic [LEN_W-1:0]        code_length;
  logic [LEN_W-1:0]        threshold;

  // Correlator state: newest bit at bit 0, oldest leaves from the top.
  logic [HISTORY_BITS-1:0] bit_history;
  logic [HISTORY_BITS-1:0] flag_delay;
  logic [HISTORY_BITS-1:0] bit_history_next;
  logic [HISTORY_BITS-1:0] flag_delay_next;
  logic [HISTORY_BITS-1:0] flag_inject;

  logic    in_xfer;
  logic    buf_full;
  result_t result;
  result_t out_result;

  // Configuration is always taken; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_word   <= '0;
      code_length <= CODE_LENGTH_RST;
      threshold   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CODE_WORD:   code_word   <= cfg_data;
        REG_CODE_LENGTH: code_length <= cfg_data[LEN_W-1:0];
        REG_THRESHOLD:   threshold   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Correlate the history as it stands before the new bit shifts in.
  swc_match #(
    .HISTORY_BITS (HISTORY_BITS)
  ) u_match (
    .bit_history (bit_history),
    .code_word   (code_word),
    .code_length (code_length),
    .threshold   (threshold),
    .flag_inject (flag_inject)
  );

  assign s_tready = !buf_full;
  assign in_xfer  = s_tvalid && s_tready;

  // Result is the oldest history bit and its flag, taken before the shift.
  assign result.data_out   = bit_history[HISTORY_BITS-1];
  assign result.match_flag = flag_delay[HISTORY_BITS-1];

  // Advance both lines; a hit drops its flag where it meets the first
  // data bit after the matched code.
  assign bit_history_next = {bit_history[HISTORY_BITS-2:0], s_tdata[0]};
  assign flag_delay_next  = {flag_delay[HISTORY_BITS-2:0], 1'b0} | flag_inject;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_history <= '0;
      flag_delay  <= '0;
    end else if (in_xfer) begin
      bit_history <= bit_history_next;
      flag_delay  <= flag_delay_next;
    end
  end

  // Hold results until the downstream side takes them.
  swc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_xfer),
    .push_data (result),
    .full      (buf_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = {7'b0, out_result.data_out};
  assign m_tuser = out_result.match_flag;

endmodule

// File: rtl/swc_checker.sv
`include "sync_word_correlator_unit_assert.svh"

module swc_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic cfg_ready
);

  // Every input transfer leaves a result waiting in the next cycle.
  `SWC_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid)
  // Input backpressure only while results are pending.
  `SWC_ASSERT_NOW(a_stall_needs_result, !s_tready, m_tvalid)
  // A stalled result stays offered.
  `SWC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  // Output is empty and both inputs are ready right after reset.
  `SWC_ASSERT_AFTER_RST(a_rst_empty, !m_tvalid && s_tready && cfg_ready)

endmodule

bind sync_word_correlator_unit swc_checker u_swc_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .cfg_ready (cfg_ready)
);
